// ----- rtl/ycrm_pkg.sv -----
// Shared types, constants and helpers for the ycbcr_range_mask block.
// Depends on nothing; imported by every other file of the block.
package ycrm_pkg;

   typedef struct packed {
      logic [7:0] pix_blue;
      logic [7:0] pix_green;
      logic [7:0] pix_red;
   } pix_type;

   typedef struct packed {
      logic       in_range;
      logic [7:0] chroma_value;
      logic [7:0] show_blue;
      logic [7:0] show_green;
      logic [7:0] show_red;
   } rsp_type;

   typedef struct packed {
      logic [8:0] luma_min;
      logic [8:0] luma_max;
      logic [8:0] red_chroma_min;
      logic [8:0] red_chroma_max;
      logic [8:0] blue_chroma_min;
      logic [8:0] blue_chroma_max;
      logic       pick_red_chroma;
   } cfg_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_LUMA_MIN        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LUMA_MAX        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_CHROMA_MIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_CHROMA_MAX  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_CHROMA_MIN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_CHROMA_MAX = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PICK_RED        = 3'd6;

   localparam logic [8:0] BOUND_MIN_RST = 9'd0;
   localparam logic [8:0] BOUND_MAX_RST = 9'd255;

   // Q14 coefficients
   localparam logic [10:0] Y_B_COEF = 11'd1868;
   localparam logic [13:0] Y_G_COEF = 14'd9617;
   localparam logic [12:0] Y_R_COEF = 13'd4899;
   localparam logic [21:0] Q_ROUND  = 22'd8192;

   localparam logic signed [15:0] CR_COEF   = 16'sd11682;
   localparam logic signed [15:0] CB_COEF   = 16'sd9241;
   localparam logic signed [15:0] SHOW_R_CR = 16'sd22987;
   localparam logic signed [15:0] SHOW_G_CR = -16'sd11698;
   localparam logic signed [15:0] SHOW_B_CB = 16'sd29049;
   localparam logic signed [15:0] SHOW_G_CB = -16'sd5636;

   localparam logic [7:0] CHROMA_MID = 8'd128;

   // Round a Q14 product, add the chroma offset and saturate to 8 bits.
   function automatic logic [7:0] chroma_out(logic signed [23:0] prod);
      logic signed [23:0] biased;
      logic signed [10:0] v;
      biased = prod + 24'sd8192;
      v = $signed({biased[23], biased[23:14]}) + 11'sd128;
      if (v < 11'sd0) begin
         chroma_out = 8'd0;
      end else if (v > 11'sd255) begin
         chroma_out = 8'd255;
      end else begin
         chroma_out = v[7:0];
      end
   endfunction

endpackage

// ----- rtl/ycbcr_range_mask.sv -----
// Top level: BGR pixel to YCrCb range mask and chroma display color.
// Six register stages, s1 through s6, lie between request acceptance and rsp_valid.
// Throughput: one pixel per clock while rsp_stall is low; the six-stage pipeline fills bubbles under stall.
// Reset clears all pipeline valid bits and loads the default ranges:
// all bounds 0..255 and blue chroma selected.
// Depends on ycrm_pkg and ycrm_pipe.
module ycbcr_range_mask (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ycrm_pkg::pix_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ycrm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ycrm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ycrm_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ycrm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LUMA_MIN:        cfg_in.luma_min        = csr_data;
            CSR_LUMA_MAX:        cfg_in.luma_max        = csr_data;
            CSR_RED_CHROMA_MIN:  cfg_in.red_chroma_min  = csr_data;
            CSR_RED_CHROMA_MAX:  cfg_in.red_chroma_max  = csr_data;
            CSR_BLUE_CHROMA_MIN: cfg_in.blue_chroma_min = csr_data;
            CSR_BLUE_CHROMA_MAX: cfg_in.blue_chroma_max = csr_data;
            CSR_PICK_RED:        cfg_in.pick_red_chroma = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.luma_min        <= BOUND_MIN_RST;
         cfg_ff.luma_max        <= BOUND_MAX_RST;
         cfg_ff.red_chroma_min  <= BOUND_MIN_RST;
         cfg_ff.red_chroma_max  <= BOUND_MAX_RST;
         cfg_ff.blue_chroma_min <= BOUND_MIN_RST;
         cfg_ff.blue_chroma_max <= BOUND_MAX_RST;
         cfg_ff.pick_red_chroma <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   ycrm_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/ycrm_pipe.sv -----
// Six-stage conversion, range test and chroma display pipeline.
// Depends on ycrm_pkg for payload, configuration types and coefficients.
module ycrm_pipe (
   input  logic              clock,
   input  logic              reset,
   input  ycrm_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  ycrm_pkg::pix_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ycrm_pkg::rsp_type rsp_data
);
   import ycrm_pkg::*;

   localparam int unsigned NSTG = 6;

   typedef struct packed {
      logic [18:0] bp;
      logic [21:0] gp;
      logic [20:0] rp;
      logic [7:0]  b;
      logic [7:0]  r;
   } s1_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] b;
      logic [7:0] r;
   } s2_type;

   typedef struct packed {
      logic [7:0]         y;
      logic signed [23:0] pr;
      logic signed [23:0] pb;
   } s3_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] cr;
      logic [7:0] cb;
   } s4_type;

   typedef struct packed {
      logic               in_range;
      logic               pick;
      logic [7:0]         sel;
      logic signed [23:0] pa;
      logic signed [23:0] pg;
   } s5_type;

   typedef struct packed {
      logic    pick;
      rsp_type rsp;
   } s6_type;

   logic [NSTG-1:0] vld_ff, vld_in, ready;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   logic [21:0]        ysum;
   logic signed [8:0]  dr, db, d;

   always_comb begin
      ready[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         ready[k] = !vld_ff[k] || ready[k+1];
      end
      vld_in[0] = ready[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = ready[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_comb begin
      s1_in.bp = 19'(req_data.pix_blue) * 19'(Y_B_COEF);
      s1_in.gp = 22'(req_data.pix_green) * 22'(Y_G_COEF);
      s1_in.rp = 21'(req_data.pix_red) * 21'(Y_R_COEF);
      s1_in.b  = req_data.pix_blue;
      s1_in.r  = req_data.pix_red;

      ysum     = 22'(s1_ff.bp) + s1_ff.gp + 22'(s1_ff.rp) + Q_ROUND;
      s2_in.y  = ysum[21:14];
      s2_in.b  = s1_ff.b;
      s2_in.r  = s1_ff.r;

      dr       = $signed({1'b0, s2_ff.r}) - $signed({1'b0, s2_ff.y});
      db       = $signed({1'b0, s2_ff.b}) - $signed({1'b0, s2_ff.y});
      s3_in.y  = s2_ff.y;
      s3_in.pr = 24'(dr) * 24'(CR_COEF);
      s3_in.pb = 24'(db) * 24'(CB_COEF);

      s4_in.y  = s3_ff.y;
      s4_in.cr = chroma_out(s3_ff.pr);
      s4_in.cb = chroma_out(s3_ff.pb);

      s5_in.in_range = ({1'b0, s4_ff.y}  >= cfg.luma_min)
                    && ({1'b0, s4_ff.y}  <= cfg.luma_max)
                    && ({1'b0, s4_ff.cr} >= cfg.red_chroma_min)
                    && ({1'b0, s4_ff.cr} <= cfg.red_chroma_max)
                    && ({1'b0, s4_ff.cb} >= cfg.blue_chroma_min)
                    && ({1'b0, s4_ff.cb} <= cfg.blue_chroma_max);
      s5_in.pick = cfg.pick_red_chroma;
      s5_in.sel  = cfg.pick_red_chroma ? s4_ff.cr : s4_ff.cb;
      d          = $signed({1'b0, s5_in.sel}) - 9'sd128;
      s5_in.pa   = 24'(d) * 24'(cfg.pick_red_chroma ? SHOW_R_CR : SHOW_B_CB);
      s5_in.pg   = 24'(d) * 24'(cfg.pick_red_chroma ? SHOW_G_CR : SHOW_G_CB);

      s6_in.pick             = s5_ff.pick;
      s6_in.rsp.in_range     = s5_ff.in_range;
      s6_in.rsp.chroma_value = s5_ff.sel;
      s6_in.rsp.show_green   = chroma_out(s5_ff.pg);
      s6_in.rsp.show_blue    = s5_ff.pick ? CHROMA_MID : chroma_out(s5_ff.pa);
      s6_in.rsp.show_red     = s5_ff.pick ? chroma_out(s5_ff.pa) : CHROMA_MID;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (ready[0]) s1_ff <= s1_in;
      if (ready[1]) s2_ff <= s2_in;
      if (ready[2]) s3_ff <= s3_in;
      if (ready[3]) s4_ff <= s4_in;
      if (ready[4]) s5_ff <= s5_in;
      if (ready[5]) s6_ff <= s6_in;
   end

   assign req_stall = !ready[0];
   assign rsp_valid = vld_ff[NSTG-1];
   assign rsp_data  = s6_ff.rsp;

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (vld_ff == {NSTG{1'b1}}))
      else $error("input stalled while pipeline has a free slot");

   a_no_mid_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && vld_ff[NSTG-2]) |=> vld_ff[NSTG-2])
      else $error("transaction dropped behind a stalled output");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && ready[1]) |=> vld_ff[1])
      else $error("transaction lost between first and second stage");

   a_mid_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (s6_ff.pick ? (rsp_data.show_blue == CHROMA_MID)
                                : (rsp_data.show_red == CHROMA_MID)))
      else $error("unselected display channel not held at mid level");

endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for ycbcr_range_mask: pixels through the range mask with
// a clocked driver/monitor pair, a local BT.601 predictor and CSR range sweeps.
// Depends on ycrm_pkg and the ycbcr_range_mask RTL.
module testbench;
   import ycrm_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 24;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_PIXELS   = 108;

   localparam int BOUND_FULL     = 0;
   localparam int BOUND_WINDOW   = 1;
   localparam int BOUND_INVERTED = 2;
   localparam int BOUND_WIDE     = 3;
   localparam int BOUND_EXTREME  = 4;
   localparam int BOUND_STYLES   = 5;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   pix_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   cfg_type   range_cfg;
   pix_type   pixel_queue[$];
   rsp_type   expected_rsp[$];
   rsp_type   want_rsp;
   int        queued_count   = 0;
   int        checked_count  = 0;
   int        in_range_count = 0;
   int        settings_count = 0;
   int        mismatches     = 0;
   int        quiet_cycles   = 0;
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;

   ycbcr_range_mask DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int q14_round(input int x);
      return (x + 8192) >>> 14;
   endfunction

   function automatic int clamp8(input int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
   endfunction

   function automatic rsp_type predict_mask(input pix_type p, input cfg_type c);
      int b, g, r, y, ys, cr, cb, d;
      rsp_type o;
      b  = p.pix_blue;
      g  = p.pix_green;
      r  = p.pix_red;
      y  = (1868 * b + 9617 * g + 4899 * r + 8192) >>> 14;
      ys = clamp8(y);
      cr = clamp8(128 + q14_round((r - y) * 11682));
      cb = clamp8(128 + q14_round((b - y) * 9241));
      if (c.pick_red_chroma) begin
         d = cr - 128;
         o.chroma_value = 8'(cr);
         o.show_blue    = CHROMA_MID;
         o.show_green   = 8'(clamp8(128 + q14_round(d * -11698)));
         o.show_red     = 8'(clamp8(128 + q14_round(d * 22987)));
      end else begin
         d = cb - 128;
         o.chroma_value = 8'(cb);
         o.show_blue    = 8'(clamp8(128 + q14_round(d * 29049)));
         o.show_green   = 8'(clamp8(128 + q14_round(d * -5636)));
         o.show_red     = CHROMA_MID;
      end
      o.in_range = (ys >= int'(c.luma_min)) && (ys <= int'(c.luma_max)) &&
                   (cr >= int'(c.red_chroma_min)) && (cr <= int'(c.red_chroma_max)) &&
                   (cb >= int'(c.blue_chroma_min)) && (cb <= int'(c.blue_chroma_max));
      return o;
   endfunction

   task automatic note_mismatch(input string what, input rsp_type want,
                                input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected mask=%0d chroma=%0d show=%0d/%0d/%0d",
                  what, want.in_range, want.chroma_value, want.show_blue,
                  want.show_green, want.show_red);
         $display("   got mask=%0d chroma=%0d show=%0d/%0d/%0d",
                  got.in_range, got.chroma_value, got.show_blue,
                  got.show_green, got.show_red);
      end
   endtask

   // Driver: hold the payload while stalled, advance on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp = {expected_rsp, predict_mask(req_data, range_cfg)};
         end
         if (!req_valid || !req_stall) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pixel_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // Monitor: compare each response transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            note_mismatch("unexpected response", '0, rsp_data);
         end else begin
            want_rsp = expected_rsp.pop_front();
            checked_count++;
            if (want_rsp.in_range) in_range_count++;
            if (rsp_data.in_range !== want_rsp.in_range ||
                rsp_data.chroma_value !== want_rsp.chroma_value ||
                rsp_data.show_blue !== want_rsp.show_blue ||
                rsp_data.show_green !== want_rsp.show_green ||
                rsp_data.show_red !== want_rsp.show_red) begin
               note_mismatch("response mismatch", want_rsp, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LUMA_MIN:        range_cfg.luma_min        = val;
         CSR_LUMA_MAX:        range_cfg.luma_max        = val;
         CSR_RED_CHROMA_MIN:  range_cfg.red_chroma_min  = val;
         CSR_RED_CHROMA_MAX:  range_cfg.red_chroma_max  = val;
         CSR_BLUE_CHROMA_MIN: range_cfg.blue_chroma_min = val;
         CSR_BLUE_CHROMA_MAX: range_cfg.blue_chroma_max = val;
         CSR_PICK_RED:        range_cfg.pick_red_chroma = val[0];
         default: ;
      endcase
   endtask

   task automatic pick_bounds(input int style, output logic [8:0] lo, output logic [8:0] hi);
      case (style)
         BOUND_FULL: begin
            lo = BOUND_MIN_RST;
            hi = BOUND_MAX_RST;
         end
         BOUND_WINDOW: begin
            lo = 9'($urandom_range(0, 180));
            hi = lo + 9'($urandom_range(20, 75));
         end
         BOUND_INVERTED: begin
            hi = 9'($urandom_range(0, 254));
            lo = 9'($urandom_range(int'(hi) + 1, 255));
         end
         BOUND_WIDE: begin
            if ($urandom_range(1)) begin
               lo = 9'($urandom_range(256, 511));
               hi = 9'd511;
            end else begin
               lo = 9'($urandom_range(0, 120));
               hi = 9'($urandom_range(256, 511));
            end
         end
         BOUND_EXTREME: begin
            lo = 9'd0;
            hi = 9'd511;
         end
         default: begin
            lo = BOUND_MIN_RST;
            hi = BOUND_MAX_RST;
         end
      endcase
   endtask

   task automatic load_ranges(input int phase, input logic pick);
      logic [8:0] lo, hi;
      write_reg(CSR_UNUSED, 9'($urandom_range(511)));
      pick_bounds((phase + 0) % BOUND_STYLES, lo, hi);
      write_reg(CSR_LUMA_MIN, lo);
      write_reg(CSR_LUMA_MAX, hi);
      pick_bounds((phase + 2) % BOUND_STYLES, lo, hi);
      write_reg(CSR_RED_CHROMA_MIN, lo);
      write_reg(CSR_RED_CHROMA_MAX, hi);
      pick_bounds((phase + 4) % BOUND_STYLES, lo, hi);
      write_reg(CSR_BLUE_CHROMA_MIN, lo);
      write_reg(CSR_BLUE_CHROMA_MAX, hi);
      write_reg(CSR_PICK_RED, {8'($urandom_range(255)), pick});
      settings_count++;
   endtask

   task automatic queue_pixel(input pix_type p);
      pixel_queue = {pixel_queue, p};
      queued_count++;
   endtask

   task automatic wait_idle();
      while (checked_count != queued_count) @(posedge clock);
   endtask

   logic [23:0] corner_pix [10] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h808080, 24'hAA55AA
   };

   initial begin
      logic [7:0] gray;
      pix_type    p;
      range_cfg = '{BOUND_MIN_RST, BOUND_MAX_RST, BOUND_MIN_RST, BOUND_MAX_RST,
                    BOUND_MIN_RST, BOUND_MAX_RST, 1'b0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_pix[i]) queue_pixel(pix_type'(corner_pix[i]));
      wait_idle();
      settings_count++;
      write_reg(CSR_PICK_RED, 9'd1);
      write_reg(CSR_LUMA_MIN, 9'd16);
      write_reg(CSR_LUMA_MAX, 9'd240);
      write_reg(CSR_UNUSED, 9'h1FF);
      settings_count++;
      foreach (corner_pix[i]) queue_pixel(pix_type'(~corner_pix[i]));
      wait_idle();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         case ((k / 2) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         load_ranges(k, k[0]);
         for (int i = 0; i < PHASE_PIXELS; i++) begin
            if ($urandom_range(2) == 0) begin
               gray = 8'($urandom_range(255));
               p.pix_green = gray;
               p.pix_blue  = gray ^ 8'($urandom_range(15));
               p.pix_red   = gray ^ 8'($urandom_range(15));
            end else begin
               p = pix_type'(24'($urandom));
            end
            queue_pixel(p);
            if (k == 3 && i == PHASE_PIXELS / 2) wait_idle();
         end
         wait_idle();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (expected_rsp.size() > 0) begin
         note_mismatch("missing response", expected_rsp.pop_front(), '0);
      end
      $display("Ran %0d pixels under %0d range settings and four idle/stall mixes",
               checked_count, settings_count);
      $display("%0d of them fell inside the configured ranges", in_range_count);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
